FILE: design/stt_pkg.sv
// Shared types and constants of the software timer table.
// No dependencies; used by every module of the block but stt_ram.
package stt_pkg;

    localparam int SLOTS_DEFAULT = 8;

    localparam int CMD_W    = 2;
    localparam int ID_W     = 8;
    localparam int PERIOD_W = 16;
    localparam int STATUS_W = 2;
    localparam int ACTIVE_W = 7;
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 24;

    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_START = 2'd1;
    localparam logic [CMD_W-1:0] CMD_STOP  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic                periodic;
        logic [PERIOD_W-1:0] counter;
        logic [PERIOD_W-1:0] period;
        logic [ID_W-1:0]     id;
    } stt_entry_t;

    typedef struct packed {
        logic                load_req;
        logic                walk_clr;
        logic                rd_last;
        logic                wr_start;
        logic                wr_update;
        logic                wr_move;
        logic                idx_inc;
        logic                used_inc;
        logic                used_dec;
        logic                fire_push;
        logic                out_clr;
        logic                out_inc;
        logic                out_single;
        logic                out_fired;
        logic [STATUS_W-1:0] status;
    } stt_ctrl_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             walk_done;
        logic             full;
        logic             hit;
        logic             oneshot;
        logic             at_last;
        logic             id_match;
        logic             out_last;
        logic             none_fired;
        logic             out_free;
    } stt_stat_t;

endpackage

FILE: design/software_timer_table.sv
// Software timer table: up to SLOTS timers kept in an entry memory with one write
// and one read port, walked one slot at a time. A start writes the new entry unless
// the table is full; a stop searches the slots in order, with a final check when the
// id is missing or a copy of the tail entry into the freed slot; a tick walks every
// slot, refills each fired one-shot slot from the tail, then sends one result per
// fired id, or a single response when nothing fires. The walk is paced by the
// one read port of the entry memory, one entry read per walk step. Requests are
// taken one at a time; the output register lets the next request in while the
// last result still waits. Depends on stt_pkg, stt_control and stt_datapath.
module software_timer_table #(
    parameter int SLOTS = stt_pkg::SLOTS_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // [7:0] task_id, [23:8] period, [24] repeat_mode, rest zero
    input  logic [stt_pkg::S_DATA_W-1:0] s_tdata,
    // [1:0] command
    input  logic [stt_pkg::CMD_W-1:0]    s_tuser,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // [7:0] fired_id, [9:8] status, [16:10] active_count, rest zero
    output logic [stt_pkg::M_DATA_W-1:0] m_tdata,
    // [0] fired_valid
    output logic                         m_tuser,
    output logic                         m_tlast
);

    stt_pkg::stt_ctrl_t ctrl;
    stt_pkg::stt_stat_t stat;

    stt_control u_control (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    stt_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .ctrl     (ctrl),
        .stat     (stat)
    );

endmodule

FILE: design/stt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module stt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: design/stt_datapath.sv
// Datapath of the software timer table: request registers, entry and fired-id
// memories, walk counters and output register. Uses stt_pkg and stt_ram.
module stt_datapath #(
    parameter int SLOTS = stt_pkg::SLOTS_DEFAULT,
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1,
    localparam int CNT_W = $clog2(SLOTS + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [stt_pkg::S_DATA_W-1:0]  s_tdata,
    input  logic [stt_pkg::CMD_W-1:0]     s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [stt_pkg::M_DATA_W-1:0]  m_tdata,
    output logic                          m_tuser,
    output logic                          m_tlast,
    input  stt_pkg::stt_ctrl_t            ctrl,
    output stt_pkg::stt_stat_t            stat
);

    logic [stt_pkg::CMD_W-1:0]    cmd_reg;
    logic [stt_pkg::ID_W-1:0]     id_reg;
    logic [stt_pkg::PERIOD_W-1:0] period_reg;
    logic                         mode_reg;

    logic [CNT_W-1:0] used_reg, used_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic [CNT_W-1:0] last_idx;

    logic                            out_valid_reg;
    logic                            out_fired_reg;
    logic [stt_pkg::ID_W-1:0]        out_id_reg;
    logic [stt_pkg::STATUS_W-1:0]    out_status_reg;
    logic [stt_pkg::ACTIVE_W-1:0]    out_active_reg;
    logic                            out_last_reg;

    stt_pkg::stt_entry_t          ent_rd, ent_wr;
    logic                         ent_we;
    logic [IDX_W-1:0]             ent_waddr, ent_raddr;
    logic [stt_pkg::PERIOD_W-1:0] cnt_inc;
    logic                         hit;
    logic [stt_pkg::ID_W-1:0]     fire_rd;

    always_ff @(posedge clk)
    begin
        if (ctrl.load_req)
        begin
            cmd_reg    <= s_tuser;
            id_reg     <= s_tdata[stt_pkg::ID_W-1:0];
            period_reg <= s_tdata[stt_pkg::ID_W +: stt_pkg::PERIOD_W];
            mode_reg   <= s_tdata[stt_pkg::ID_W + stt_pkg::PERIOD_W];
        end
    end

    assign last_idx = used_reg - CNT_W'(1);
    assign cnt_inc  = ent_rd.counter + stt_pkg::PERIOD_W'(1);
    assign hit      = (cnt_inc == ent_rd.period);

    always_comb
    begin
        ent_we    = ctrl.wr_start | ctrl.wr_update | ctrl.wr_move;
        ent_waddr = ctrl.wr_start ? used_reg[IDX_W-1:0] : idx_reg[IDX_W-1:0];
        ent_raddr = ctrl.rd_last ? last_idx[IDX_W-1:0] : idx_reg[IDX_W-1:0];
        ent_wr    = ent_rd;
        if (ctrl.wr_start)
        begin
            ent_wr.periodic = mode_reg;
            ent_wr.counter  = '0;
            ent_wr.period   = period_reg;
            ent_wr.id       = id_reg;
        end
        else if (ctrl.wr_update)
        begin
            ent_wr.counter = hit ? '0 : cnt_inc;
        end
    end

    stt_ram #(
        .WIDTH ($bits(stt_pkg::stt_entry_t)),
        .DEPTH (SLOTS)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (ent_wr),
        .raddr (ent_raddr),
        .rdata (ent_rd)
    );

    stt_ram #(
        .WIDTH (stt_pkg::ID_W),
        .DEPTH (SLOTS)
    ) u_fire_ram (
        .clk   (clk),
        .we    (ctrl.fire_push),
        .waddr (k_reg[IDX_W-1:0]),
        .wdata (ent_rd.id),
        .raddr (j_reg[IDX_W-1:0]),
        .rdata (fire_rd)
    );

    always_comb
    begin
        used_next = used_reg;
        idx_next  = idx_reg;
        k_next    = k_reg;
        j_next    = j_reg;
        if (ctrl.used_inc)
        begin
            used_next = used_reg + CNT_W'(1);
        end
        else if (ctrl.used_dec)
        begin
            used_next = last_idx;
        end
        if (ctrl.walk_clr)
        begin
            idx_next = '0;
            k_next   = '0;
        end
        else
        begin
            if (ctrl.idx_inc)
            begin
                idx_next = idx_reg + CNT_W'(1);
            end
            if (ctrl.fire_push)
            begin
                k_next = k_reg + CNT_W'(1);
            end
        end
        if (ctrl.out_clr)
        begin
            j_next = '0;
        end
        else if (ctrl.out_inc)
        begin
            j_next = j_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= '0;
            idx_reg       <= '0;
            k_reg         <= '0;
            j_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            used_reg <= used_next;
            idx_reg  <= idx_next;
            k_reg    <= k_next;
            j_reg    <= j_next;
            if (ctrl.out_single || ctrl.out_fired)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.out_single)
        begin
            out_fired_reg  <= 1'b0;
            out_id_reg     <= '0;
            out_status_reg <= ctrl.status;
            out_active_reg <= stt_pkg::ACTIVE_W'(used_reg);
            out_last_reg   <= 1'b1;
        end
        else if (ctrl.out_fired)
        begin
            out_fired_reg  <= 1'b1;
            out_id_reg     <= fire_rd;
            out_status_reg <= stt_pkg::ST_OK;
            out_active_reg <= stt_pkg::ACTIVE_W'(used_reg);
            out_last_reg   <= stat.out_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_fired_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(stt_pkg::M_DATA_W - stt_pkg::ACTIVE_W - stt_pkg::STATUS_W
                         - stt_pkg::ID_W){1'b0}},
                       out_active_reg, out_status_reg, out_id_reg};

    always_comb
    begin
        stat.cmd        = cmd_reg;
        stat.walk_done  = (idx_reg >= used_reg);
        stat.full       = (used_reg >= CNT_W'(SLOTS));
        stat.hit        = hit;
        stat.oneshot    = ~ent_rd.periodic;
        stat.at_last    = (idx_reg == last_idx);
        stat.id_match   = (ent_rd.id == id_reg);
        stat.out_last   = (j_reg == k_reg - CNT_W'(1));
        stat.none_fired = (k_reg == '0);
        stat.out_free   = ~out_valid_reg | m_tready;
    end

endmodule

FILE: design/stt_control.sv
// Controller state machine of the software timer table.
// Uses stt_pkg; drives the datapath through stt_ctrl_t.
module stt_control (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  stt_pkg::stt_stat_t stat,
    output stt_pkg::stt_ctrl_t ctrl
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_READ   = 3'd2;
    localparam logic [2:0] S_EVAL   = 3'd3;
    localparam logic [2:0] S_MOVE   = 3'd4;
    localparam logic [2:0] S_RESP   = 3'd5;
    localparam logic [2:0] S_OUT_RD = 3'd6;
    localparam logic [2:0] S_OUT    = 3'd7;

    logic [2:0]                   state_reg, state_next;
    logic [stt_pkg::STATUS_W-1:0] status_reg, status_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        status_next = status_reg;
        ctrl        = '0;
        ctrl.status = status_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    ctrl.load_req = 1'b1;
                    state_next    = S_DECODE;
                end
            end
            S_DECODE:
            begin
                status_next = stt_pkg::ST_OK;
                if (stat.cmd == stt_pkg::CMD_START)
                begin
                    if (stat.full)
                    begin
                        status_next = stt_pkg::ST_FULL;
                    end
                    else
                    begin
                        ctrl.wr_start = 1'b1;
                        ctrl.used_inc = 1'b1;
                    end
                    state_next = S_RESP;
                end
                else if (stat.cmd == stt_pkg::CMD_TICK || stat.cmd == stt_pkg::CMD_STOP)
                begin
                    ctrl.walk_clr = 1'b1;
                    state_next    = S_READ;
                end
                else
                begin
                    state_next = S_RESP;
                end
            end
            S_READ:
            begin
                if (!stat.walk_done)
                begin
                    state_next = S_EVAL;
                end
                else if (stat.cmd == stt_pkg::CMD_STOP)
                begin
                    status_next = stt_pkg::ST_NOT_FOUND;
                    state_next  = S_RESP;
                end
                else if (stat.none_fired)
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    ctrl.out_clr = 1'b1;
                    state_next   = S_OUT_RD;
                end
            end
            S_EVAL:
            begin
                if (stat.cmd == stt_pkg::CMD_STOP)
                begin
                    if (stat.id_match)
                    begin
                        ctrl.used_dec = 1'b1;
                        if (stat.at_last)
                        begin
                            state_next = S_RESP;
                        end
                        else
                        begin
                            ctrl.rd_last = 1'b1;
                            state_next   = S_MOVE;
                        end
                    end
                    else
                    begin
                        ctrl.idx_inc = 1'b1;
                        state_next   = S_READ;
                    end
                end
                else
                begin
                    ctrl.fire_push = stat.hit;
                    if (stat.hit && stat.oneshot)
                    begin
                        // slot refilled from the tail (unless it is the last), evaluated next cycle
                        ctrl.used_dec = 1'b1;
                        if (stat.at_last)
                        begin
                            state_next = S_READ;
                        end
                        else
                        begin
                            ctrl.rd_last = 1'b1;
                            state_next   = S_EVAL;
                        end
                    end
                    else
                    begin
                        ctrl.wr_update = 1'b1;
                        ctrl.idx_inc   = 1'b1;
                        state_next     = S_READ;
                    end
                end
            end
            S_MOVE:
            begin
                ctrl.wr_move = 1'b1;
                state_next   = S_RESP;
            end
            S_RESP:
            begin
                if (stat.out_free)
                begin
                    ctrl.out_single = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_OUT_RD:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (stat.out_free)
                begin
                    ctrl.out_fired = 1'b1;
                    ctrl.out_inc   = 1'b1;
                    state_next     = stat.out_last ? S_IDLE : S_OUT_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            status_reg <= stt_pkg::ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            status_reg <= status_next;
        end
    end

endmodule
